// File: src/kda_pkg.sv
// Shared types, constants and helpers for the key debounce and auto-repeat block.
package kda_pkg;

	localparam int KEYS = 16;
	localparam logic [15:0] KEY_MASK = 16'((32'd1 << KEYS) - 32'd1);

	localparam logic [3:0] DEBOUNCE_COUNT_RESET = 4'd5;
	localparam logic [7:0] SCAN_PERIOD_RESET = 8'd2;

	// item commands
	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_QUERY     = 3'd1,
		CMD_MASK_BITS = 3'd2,
		CMD_MASK_KEY  = 3'd3,
		CMD_RECAPTURE = 3'd4
	} cmd_t;

	// query answers
	typedef enum logic [1:0] {
		RES_NONE      = 2'd0,
		RES_PUSH_DOWN = 2'd1,
		RES_PUSH_UP   = 2'd2,
		RES_CONTINUE  = 2'd3
	} key_res_t;

	// configuration register indexes
	typedef enum logic {
		REG_DEBOUNCE_COUNT = 1'b0,
		REG_SCAN_PERIOD    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] pin_word;
		logic [3:0]  key_index;
		logic [15:0] first_delay;
		logic [15:0] repeat_delay;
		logic        no_repeat;
		logic [15:0] mask_bits;
	} item_t;

	typedef struct packed {
		logic        scan_event;
		logic [1:0]  key_result;
	} result_t;

	typedef struct packed {
		logic [3:0] debounce_count;
		logic [7:0] scan_period;
	} cfg_t;

	// one-hot bit of a key, zero when the key does not exist
	function automatic logic [15:0] key_bit(input logic [3:0] idx);
		logic [16:0] one;
		one = 17'd1 << idx;
		return one[15:0] & KEY_MASK;
	endfunction

endpackage

// File: src/key_debounce_autorepeat.sv
// An accepted item passes the input register and then the result register before its result shows.
// Throughput: one item per cycle; the state update is a single pass in kda_core.
// The input stage stalls only while the result register holds an item the sink stalls.
// Reset: asynchronous, clears all key state, timers and valid flags; debounce count 5,
// scan period 2.
module key_debounce_autorepeat (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  kda_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output kda_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);

	logic              valid_s1;
	kda_pkg::item_t    item_s1;
	logic              valid_s2;
	kda_pkg::result_t  result_s2;
	kda_pkg::cfg_t     cfg_q;
	kda_pkg::result_t  core_res;
	logic              advance;

	assign cfg_ready = 1'b1;

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count <= kda_pkg::DEBOUNCE_COUNT_RESET;
			cfg_q.scan_period    <= kda_pkg::SCAN_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kda_pkg::REG_DEBOUNCE_COUNT: cfg_q.debounce_count <= cfg_data[3:0];
				kda_pkg::REG_SCAN_PERIOD:    cfg_q.scan_period    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// advance stage 1 when the result register is free or draining
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	kda_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef ASSERT_OFF
	// stall input only when the result register is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s2 && result_stall))
		else $error("input stalled while result path is free");

	// a blocked item in stage 1 is kept
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage 1 item lost");

	// a taken result with nothing behind it leaves the output empty
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result_stall && !valid_s1) |=> !result_valid)
		else $error("result repeated or invented");

	// a scan event and a key answer never come from the same item
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.scan_event && result.key_result != kda_pkg::RES_NONE))
		else $error("scan event and key result both set");
`endif

endmodule

// File: src/kda_core.sv
// Key state registers and the single-pass update for one item.
module kda_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  kda_pkg::item_t    item,
	input  kda_pkg::cfg_t     cfg,
	output kda_pkg::result_t  res
);

	logic [15:0] last_word_q, change_word_q, held_word_q, mask_once_q, repeat_word_q;
	logic [3:0]  change_count_q, hold_count_q;
	logic [7:0]  scan_timer_q;
	logic [15:0] first_timer_q, repeat_timer_q;

	logic [15:0] last_word_d, change_word_d, held_word_d, mask_once_d, repeat_word_d;
	logic [3:0]  change_count_d, hold_count_d;
	logic [7:0]  scan_timer_d;
	logic [15:0] first_timer_d, repeat_timer_d;

	logic [15:0] pins, mbits, kbit;
	logic [4:0]  cnt_inc;
	logic        ev;
	logic [1:0]  kres;

	// compute next state and result of the item in stage 1
	always_comb begin
		pins  = item.pin_word & kda_pkg::KEY_MASK;
		mbits = item.mask_bits & kda_pkg::KEY_MASK;
		kbit  = kda_pkg::key_bit(item.key_index);
		cnt_inc = 5'd0;
		ev   = 1'b0;
		kres = kda_pkg::RES_NONE;

		last_word_d    = last_word_q;
		change_word_d  = change_word_q;
		held_word_d    = held_word_q;
		mask_once_d    = mask_once_q;
		repeat_word_d  = repeat_word_q;
		change_count_d = change_count_q;
		hold_count_d   = hold_count_q;
		scan_timer_d   = scan_timer_q;
		first_timer_d  = first_timer_q;
		repeat_timer_d = repeat_timer_q;

		case (item.cmd)
			kda_pkg::CMD_TICK: begin
				// count timers down, stop at zero
				if (first_timer_q != 16'd0) first_timer_d = first_timer_q - 16'd1;
				if (repeat_timer_q != 16'd0) repeat_timer_d = repeat_timer_q - 16'd1;
				if (scan_timer_q != 8'd0) scan_timer_d = scan_timer_q - 8'd1;
				if (scan_timer_d == 8'd0) begin
					scan_timer_d = cfg.scan_period;
					if (pins != last_word_q) begin
						// new level: accept once it outlasts the debounce count
						cnt_inc = {1'b0, change_count_q} + 5'd1;
						hold_count_d = 4'd0;
						if (cnt_inc > {1'b0, cfg.debounce_count}) begin
							change_count_d = 4'd0;
							change_word_d  = pins ^ last_word_q;
							last_word_d    = pins;
							held_word_d    = pins;
							ev = 1'b1;
						end else begin
							change_count_d = cnt_inc[3:0];
						end
					end else if (pins != 16'd0) begin
						// steady press: refresh the held word
						cnt_inc = {1'b0, hold_count_q} + 5'd1;
						change_count_d = 4'd0;
						if (cnt_inc > {1'b0, cfg.debounce_count}) begin
							hold_count_d = 4'd0;
							held_word_d  = pins;
							ev = 1'b1;
						end else begin
							hold_count_d = cnt_inc[3:0];
						end
					end else begin
						// all released: drop held, mask and repeat state
						change_count_d = 4'd0;
						hold_count_d   = 4'd0;
						held_word_d    = 16'd0;
						mask_once_d    = 16'd0;
						repeat_word_d  = 16'd0;
					end
				end
			end
			kda_pkg::CMD_QUERY: begin
				if (kbit != 16'd0 && (mask_once_q & kbit) == 16'd0) begin
					if ((repeat_word_q & kbit) != 16'd0) begin
						// repeating key: report release or the next repeat
						if ((change_word_q & kbit) != 16'd0) begin
							change_word_d = 16'd0;
							if ((held_word_q & kbit) == 16'd0) kres = kda_pkg::RES_PUSH_UP;
						end
						if (kres == kda_pkg::RES_NONE && (held_word_q & kbit) != 16'd0
								&& first_timer_q == 16'd0 && repeat_timer_q == 16'd0) begin
							repeat_timer_d = item.repeat_delay;
							kres = kda_pkg::RES_CONTINUE;
						end
					end else if ((change_word_q & kbit) != 16'd0) begin
						// fresh edge on the key
						change_word_d = 16'd0;
						if ((held_word_q & kbit) != 16'd0) begin
							if (!item.no_repeat) begin
								repeat_word_d = repeat_word_q | kbit;
								first_timer_d = item.first_delay;
							end else begin
								first_timer_d = 16'd0;
							end
							repeat_timer_d = 16'd0;
							kres = kda_pkg::RES_PUSH_DOWN;
						end else begin
							kres = kda_pkg::RES_PUSH_UP;
						end
					end
				end
			end
			kda_pkg::CMD_MASK_BITS: mask_once_d = mask_once_q | mbits;
			kda_pkg::CMD_MASK_KEY:  mask_once_d = mask_once_q | kbit;
			kda_pkg::CMD_RECAPTURE: last_word_d = last_word_q & ~kbit;
			default: begin
			end
		endcase

		res.scan_event = ev;
		res.key_result = kres;
	end

	// commit state when the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_word_q    <= '0;
			change_word_q  <= '0;
			held_word_q    <= '0;
			mask_once_q    <= '0;
			repeat_word_q  <= '0;
			change_count_q <= '0;
			hold_count_q   <= '0;
			scan_timer_q   <= '0;
			first_timer_q  <= '0;
			repeat_timer_q <= '0;
		end else if (fire) begin
			last_word_q    <= last_word_d;
			change_word_q  <= change_word_d;
			held_word_q    <= held_word_d;
			mask_once_q    <= mask_once_d;
			repeat_word_q  <= repeat_word_d;
			change_count_q <= change_count_d;
			hold_count_q   <= hold_count_d;
			scan_timer_q   <= scan_timer_d;
			first_timer_q  <= first_timer_d;
			repeat_timer_q <= repeat_timer_d;
		end
	end

endmodule

// File: sim/key_debounce_autorepeat_tb.sv
// Self-checking testbench for the 16-key debouncer with push, release and auto-repeat events.

module key_debounce_autorepeat_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Tracks the key state and the item stream, and matches results in order
	class keypad_event_tracker;
		logic [3:0]  cfg_debounce;
		logic [7:0]  cfg_period;
		logic [15:0] pins_seen;
		logic [15:0] pending_change;
		logic [15:0] held_keys;
		logic [15:0] suppress_once;
		logic [15:0] repeating;
		logic [3:0]  change_run;
		logic [3:0]  hold_run;
		logic [7:0]  scan_left;
		logic [15:0] first_left;
		logic [15:0] repeat_left;
		kda_pkg::result_t awaited_results[$];
		int mismatch_count;

		function new();
			cfg_debounce = kda_pkg::DEBOUNCE_COUNT_RESET;
			cfg_period = kda_pkg::SCAN_PERIOD_RESET;
			pins_seen = '0;
			pending_change = '0;
			held_keys = '0;
			suppress_once = '0;
			repeating = '0;
			change_run = '0;
			hold_run = '0;
			scan_left = '0;
			first_left = '0;
			repeat_left = '0;
			mismatch_count = 0;
		endfunction

		function void set_register(kda_pkg::reg_idx_t idx, logic [7:0] data);
			if (idx == kda_pkg::REG_DEBOUNCE_COUNT)
				cfg_debounce = data[3:0];
			else
				cfg_period = data;
		endfunction

		function logic [15:0] bit_of_key(logic [3:0] idx);
			return (16'd1 << idx) & kda_pkg::KEY_MASK;
		endfunction

		// Count down the timers and, on a scan, run the debounce
		function logic scan_tick(logic [15:0] raw);
			logic [15:0] pins;
			logic [4:0]  run;
			pins = raw & kda_pkg::KEY_MASK;
			if (first_left != 0) first_left = first_left - 16'd1;
			if (repeat_left != 0) repeat_left = repeat_left - 16'd1;
			if (scan_left != 0) scan_left = scan_left - 8'd1;
			if (scan_left != 0) return 1'b0;
			scan_left = cfg_period;
			if (pins != pins_seen) begin
				run = {1'b0, change_run} + 5'd1;
				hold_run = '0;
				if (run > {1'b0, cfg_debounce}) begin
					change_run = '0;
					pending_change = (pins ^ pins_seen) & kda_pkg::KEY_MASK;
					pins_seen = pins;
					held_keys = pins;
					return 1'b1;
				end
				change_run = run[3:0];
			end else if (pins != 0) begin
				run = {1'b0, hold_run} + 5'd1;
				change_run = '0;
				if (run > {1'b0, cfg_debounce}) begin
					hold_run = '0;
					held_keys = pins;
					return 1'b1;
				end
				hold_run = run[3:0];
			end else begin
				change_run = '0;
				hold_run = '0;
				held_keys = '0;
				suppress_once = '0;
				repeating = '0;
			end
			return 1'b0;
		endfunction

		// Answer a query for one key; a pending change clears the whole change word
		function kda_pkg::key_res_t query_key(logic [3:0] idx, logic [15:0] fdel,
				logic [15:0] rdel, logic once);
			logic [15:0] kb;
			kb = bit_of_key(idx);
			if (kb == 0 || (suppress_once & kb) != 0) return kda_pkg::RES_NONE;
			if ((repeating & kb) != 0) begin
				if ((pending_change & kb) != 0) begin
					pending_change = '0;
					if ((held_keys & kb) == 0) return kda_pkg::RES_PUSH_UP;
				end
				if ((held_keys & kb) != 0 && first_left == 0 && repeat_left == 0) begin
					repeat_left = rdel;
					return kda_pkg::RES_CONTINUE;
				end
				return kda_pkg::RES_NONE;
			end
			if ((pending_change & kb) != 0) begin
				pending_change = '0;
				if ((held_keys & kb) != 0) begin
					if (!once) begin
						repeating = repeating | kb;
						first_left = fdel;
					end else begin
						first_left = '0;
					end
					repeat_left = '0;
					return kda_pkg::RES_PUSH_DOWN;
				end
				return kda_pkg::RES_PUSH_UP;
			end
			return kda_pkg::RES_NONE;
		endfunction

		// Apply an accepted item and queue the result it must produce
		function void note_item(kda_pkg::item_t it);
			kda_pkg::result_t want;
			want = '0;
			case (it.cmd)
				kda_pkg::CMD_TICK: want.scan_event = scan_tick(it.pin_word);
				kda_pkg::CMD_QUERY: want.key_result = query_key(it.key_index, it.first_delay,
						it.repeat_delay, it.no_repeat);
				kda_pkg::CMD_MASK_BITS: suppress_once = suppress_once |
						(it.mask_bits & kda_pkg::KEY_MASK);
				kda_pkg::CMD_MASK_KEY: suppress_once = suppress_once | bit_of_key(it.key_index);
				kda_pkg::CMD_RECAPTURE: pins_seen = pins_seen & ~bit_of_key(it.key_index) &
						kda_pkg::KEY_MASK;
				default: ;
			endcase
			awaited_results.push_back(want);
		endfunction

		task report(string what);
			mismatch_count++;
			$display("%0t: mismatch: %s", $time, what);
		endtask

		// Compare one accepted result with the oldest expectation
		task check_result(kda_pkg::result_t got);
			kda_pkg::result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("result %b/%0d with nothing awaited", got.scan_event,
						got.key_result));
			end else begin
				want = awaited_results.pop_front();
				if (got.scan_event !== want.scan_event)
					report($sformatf("scan_event %b, expected %b", got.scan_event,
							want.scan_event));
				if (got.key_result !== want.key_result)
					report($sformatf("key_result %0d, expected %0d", got.key_result,
							want.key_result));
			end
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	kda_pkg::item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	kda_pkg::result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;

	keypad_event_tracker tracker = new();

	int burst_left = 0;
	int cur_db = kda_pkg::DEBOUNCE_COUNT_RESET;
	int cur_sp = kda_pkg::SCAN_PERIOD_RESET;
	int stall_mode = 0;
	int stall_left = 0;

	key_debounce_autorepeat dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard limit on the run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Stall the result side in changing patterns
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 1) == 0);
			default: result_stall <= stall_left[2];
		endcase
	end

	// Check every accepted result
	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(result);

	// Present one item and hold it until accepted; pause between bursts
	task automatic drive_item(input kda_pkg::item_t it);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		tracker.note_item(it);
		burst_left--;
		if (burst_left == 0) item_valid <= 1'b0;
	endtask

	task automatic end_stream();
		if (burst_left != 0) begin
			item_valid <= 1'b0;
			burst_left = 0;
		end
	endtask

	// Wait until every awaited result has come, then let the pipeline settle
	task automatic drain();
		end_stream();
		while (tracker.awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic kda_pkg::item_t random_item();
		logic [95:0] r;
		r = {$urandom, $urandom, $urandom};
		return r[71:0];
	endfunction

	function automatic logic [15:0] random_delay();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) return 16'($urandom_range(0, 8));
		if (pick < 8) return 16'd0;
		if (pick == 8) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic send_tick(input logic [15:0] pins);
		kda_pkg::item_t it;
		it = random_item();
		it.cmd = kda_pkg::CMD_TICK;
		it.pin_word = pins;
		drive_item(it);
	endtask

	task automatic send_query(input logic [3:0] idx, input logic [15:0] fdel,
			input logic [15:0] rdel, input logic once);
		kda_pkg::item_t it;
		it = random_item();
		it.cmd = kda_pkg::CMD_QUERY;
		it.key_index = idx;
		it.first_delay = fdel;
		it.repeat_delay = rdel;
		it.no_repeat = once;
		drive_item(it);
	endtask

	task automatic send_cmd(input kda_pkg::cmd_t op, input logic [3:0] idx,
			input logic [15:0] mbits);
		kda_pkg::item_t it;
		it = random_item();
		it.cmd = op;
		it.key_index = idx;
		it.mask_bits = mbits;
		drive_item(it);
	endtask

	// Write both registers back to back on an idle block
	task automatic write_settings(input logic [7:0] db_data, input logic [7:0] sp_data);
		cfg_index <= kda_pkg::REG_DEBOUNCE_COUNT;
		cfg_data <= db_data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_register(kda_pkg::REG_DEBOUNCE_COUNT, db_data);
		cfg_index <= kda_pkg::REG_SCAN_PERIOD;
		cfg_data <= sp_data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_register(kda_pkg::REG_SCAN_PERIOD, sp_data);
		cfg_valid <= 1'b0;
		cur_db = db_data[3:0];
		cur_sp = sp_data;
	endtask

	// Mostly one to three keys, now and then any word
	function automatic logic [15:0] pick_word();
		logic [15:0] w;
		if ($urandom_range(0, 4) == 0) return 16'($urandom);
		w = '0;
		repeat ($urandom_range(1, 3)) w[$urandom_range(0, 15)] = 1'b1;
		return w;
	endfunction

	// Prefer a key that is down in the given word
	function automatic logic [3:0] pick_key(input logic [15:0] w);
		logic [3:0] k;
		k = 4'($urandom_range(0, 15));
		if (w != 0 && $urandom_range(0, 3) != 0)
			while (!w[k]) k = 4'($urandom_range(0, 15));
		return k;
	endfunction

	// Ticks of one level, with queries on the keys mixed in; stop at the phase budget
	task automatic hold_level(input logic [15:0] w, input int ticks, input int count,
			inout int sent);
		for (int t = 0; t < ticks && sent < count; t++) begin
			send_tick(w);
			sent++;
			if ($urandom_range(0, 2) == 0) begin
				send_query(pick_key(w), random_delay(), random_delay(),
						$urandom_range(0, 3) == 0);
				sent++;
			end
		end
	endtask

	// Press and release episodes with bounce, plus masks and noise
	task automatic play_phase(input int count);
		int sent;
		int span;
		int pick;
		int ticks;
		logic [15:0] w;
		kda_pkg::item_t it;
		sent = 0;
		span = (cur_db + 1) * ((cur_sp == 0) ? 1 : cur_sp);
		while (sent < count) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				w = pick_word();
				repeat ($urandom_range(0, 2)) begin
					send_tick(16'($urandom));
					sent++;
				end
				ticks = span + $urandom_range(0, span + 8);
				if (ticks > 60) ticks = $urandom_range(20, 60);
				hold_level(w, ticks, count, sent);
				if ($urandom_range(0, 2) == 0) begin
					hold_level(w & 16'($urandom), ticks, count, sent);
				end
				ticks = span + $urandom_range(0, span);
				if (ticks > 60) ticks = $urandom_range(20, 60);
				hold_level(16'd0, ticks, count, sent);
			end else if (pick < 9) begin
				case ($urandom_range(0, 2))
					0: send_cmd(kda_pkg::CMD_MASK_BITS, 4'($urandom), pick_word());
					1: send_cmd(kda_pkg::CMD_MASK_KEY, pick_key(tracker.held_keys),
							16'($urandom));
					default: send_cmd(kda_pkg::CMD_RECAPTURE, pick_key(tracker.pins_seen),
							16'($urandom));
				endcase
				send_query(pick_key(tracker.held_keys), random_delay(), random_delay(),
						$urandom_range(0, 1));
				sent += 2;
			end else begin
				it = random_item();
				drive_item(it);
				if (it.cmd <= kda_pkg::CMD_RECAPTURE) sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings first
		play_phase(100);
		drain();

		// Zero debounce and zero scan period: every tick scans and accepts at once
		write_settings(8'd0, 8'd0);
		send_tick(16'hFFFF);
		send_query(4'd15, 16'd0, 16'd0, 1'b0);
		send_query(4'd15, 16'hFFFF, 16'd0, 1'b0);
		send_query(4'd15, 16'd0, 16'hFFFF, 1'b0);
		send_query(4'd15, 16'd0, 16'd0, 1'b0);
		send_query(4'd0, 16'd0, 16'd0, 1'b0);
		send_tick(16'hFFFF);
		send_tick(16'h0001);
		send_query(4'd1, 16'd0, 16'd0, 1'b1);
		send_cmd(kda_pkg::CMD_MASK_KEY, 4'd0, 16'd0);
		send_query(4'd0, 16'd0, 16'd0, 1'b0);
		send_cmd(kda_pkg::CMD_MASK_BITS, 4'd0, 16'h8000);
		send_cmd(kda_pkg::CMD_RECAPTURE, 4'd15, 16'h0000);
		send_cmd(kda_pkg::CMD_RECAPTURE, 4'd0, 16'hFFFF);
		send_tick(16'h0001);
		send_tick(16'h0000);
		send_tick(16'h0000);
		send_query(4'd0, 16'd0, 16'd0, 1'b0);
		send_tick(16'h0002);
		send_query(4'd1, 16'hFFFF, 16'hFFFF, 1'b1);
		send_query(4'd1, 16'd0, 16'd0, 1'b0);
		send_tick(16'h0006);
		send_query(4'd2, 16'hFFFF, 16'd0, 1'b0);
		send_query(4'd2, 16'd0, 16'd0, 1'b0);
		// Unknown commands leave the state alone
		for (int c = kda_pkg::CMD_RECAPTURE + 1; c < 8; c++) begin
			begin : unknown_cmd
				kda_pkg::item_t it;
				it = random_item();
				it.cmd = 3'(c);
				drive_item(it);
			end
		end
		play_phase(100);
		drain();

		write_settings(8'd1, 8'd1);
		play_phase(150);
		drain();

		// Upper bits of the debounce write are dropped
		write_settings(8'hF3, 8'd2);
		play_phase(120);
		drain();

		write_settings(8'd15, 8'd1);
		play_phase(100);
		drain();

		write_settings(8'd2, 8'd3);
		play_phase(100);
		drain();

		write_settings(8'd1, 8'd255);
		play_phase(40);
		drain();

		write_settings(8'd15, 8'd255);
		play_phase(40);
		drain();

		if (tracker.mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
